### sv/lr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lr_pkg: shared types and constants of the line rasterizer
// Sequencer states, shared adder operand selects, control and status bundles.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int COORD_W     = 6;
    localparam int ERR_W       = 9;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 16;

    typedef logic [COORD_W-1:0]       coord_t;
    typedef logic signed [ERR_W-1:0]  err_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DX,
        ST_DY,
        ST_ADX,
        ST_ADY,
        ST_CMP,
        ST_ERR,
        ST_INC,
        ST_RUN
    } lr_state_t;

    typedef enum logic [3:0] {
        SEL_NONE,
        SEL_DX,
        SEL_DY,
        SEL_ADX,
        SEL_ADY,
        SEL_CMP,
        SEL_ERR,
        SEL_INC,
        SEL_STEP
    } alu_sel_t;

    typedef struct packed {
        logic     in_ready;
        alu_sel_t alu_sel;
        logic     step;
    } lr_ctrl_t;

    typedef struct packed {
        logic major_zero;
        logic last_step;
        logic out_free;
    } lr_stat_t;

    function automatic coord_t clamp_coord(input coord_t v, input coord_t max_c);
        clamp_coord = (v > max_c) ? max_c : v;
    endfunction

endpackage
`default_nettype wire

### sv/lr_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lr_alu: shared adder of the line rasterizer
// Signed add or subtract, used for setup arithmetic and every error update.
// ----------------------------------------------------------------------------
module lr_alu
    import lr_pkg::*;
(
    input  wire err_t a,
    input  wire err_t b,
    input  wire logic sub,
    output err_t      sum
);

    assign sum = sub ? err_t'(a - b) : err_t'(a + b);

endmodule
`default_nettype wire

### sv/lr_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lr_seq: sequencer of the line rasterizer
// Walks setup through the shared adder, then steps one pixel per free slot.
// ----------------------------------------------------------------------------
module lr_seq
    import lr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire lr_stat_t stat,
    output lr_ctrl_t      ctrl
);

    lr_state_t state_reg;
    lr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DX;
                end
            end
            ST_DX:  state_next = ST_DY;
            ST_DY:  state_next = ST_ADX;
            ST_ADX: state_next = ST_ADY;
            ST_ADY: state_next = ST_CMP;
            ST_CMP: state_next = ST_ERR;
            ST_ERR: state_next = stat.major_zero ? ST_IDLE : ST_INC;
            ST_INC: state_next = ST_RUN;
            ST_RUN:
            begin
                if (stat.out_free && stat.last_step)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.in_ready = 1'b0;
        ctrl.alu_sel  = SEL_NONE;
        ctrl.step     = 1'b0;
        case (state_reg)
            ST_IDLE: ctrl.in_ready = 1'b1;
            ST_DX:   ctrl.alu_sel  = SEL_DX;
            ST_DY:   ctrl.alu_sel  = SEL_DY;
            ST_ADX:  ctrl.alu_sel  = SEL_ADX;
            ST_ADY:  ctrl.alu_sel  = SEL_ADY;
            ST_CMP:  ctrl.alu_sel  = SEL_CMP;
            ST_ERR:  ctrl.alu_sel  = SEL_ERR;
            ST_INC:  ctrl.alu_sel  = SEL_INC;
            ST_RUN:
            begin
                ctrl.alu_sel = SEL_STEP;
                ctrl.step    = stat.out_free;
            end
            default: ctrl.in_ready = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

### sv/line_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_rasterizer: integer Bresenham line rasterizer for one square tile
// Takes one segment and emits its pixels after the start, end pixel last.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_axis    in   s_tvalid/s_tready  s_tdata: start_x, start_y, end_x, end_y
//  m_axis    out  m_tvalid/m_tready  m_tdata: pix_x, pix_y; m_tlast: last
//
//  A segment walks its setup steps through the shared adder (DX, DY, ADX, ADY,
//  CMP, ERR, INC; a zero-length segment goes idle after ERR), then steps its
//  pixels one at a time along the major axis.
//  The shared adder and its sequencer serialize this work; s_tready is low meanwhile.
//  A stall on m_tready holds the pixel step; the output register parts the sides.
//  Reset clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module line_rasterizer
    import lr_pkg::*;
#(
    parameter int TILE_SIZE = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // start_x, start_y, end_x, end_y
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // pix_x, pix_y, zero pad
    output logic                      m_tlast    // last
);

    localparam coord_t MAX_C = coord_t'(TILE_SIZE - 1);

    lr_ctrl_t ctrl;
    lr_stat_t stat;

    coord_t x_reg, y_reg, ex_reg, ey_reg;
    err_t   dx_reg, dy_reg, err_reg, inc_move_reg;
    logic   sx_neg_reg, sy_neg_reg, x_major_reg;
    coord_t cnt_reg;

    logic   m_tvalid_reg, last_reg;
    coord_t pix_x_reg, pix_y_reg;

    err_t   alu_a, alu_b, alu_sum;
    logic   alu_sub;
    err_t   major, minor, minor2;
    logic   move_minor;
    coord_t x_step, y_step;

    assign major  = x_major_reg ? dx_reg : dy_reg;
    assign minor  = x_major_reg ? dy_reg : dx_reg;
    assign minor2 = err_t'(minor <<< 1);
    assign move_minor = !err_reg[ERR_W-1];

    assign x_step = sx_neg_reg ? coord_t'(x_reg - 1'b1) : coord_t'(x_reg + 1'b1);
    assign y_step = sy_neg_reg ? coord_t'(y_reg - 1'b1) : coord_t'(y_reg + 1'b1);

    assign stat.major_zero = (major == '0);
    assign stat.last_step  = (cnt_reg == coord_t'(1));
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (ctrl.alu_sel)
            SEL_DX:
            begin
                alu_a   = err_t'(ex_reg);
                alu_b   = err_t'(x_reg);
                alu_sub = 1'b1;
            end
            SEL_DY:
            begin
                alu_a   = err_t'(ey_reg);
                alu_b   = err_t'(y_reg);
                alu_sub = 1'b1;
            end
            SEL_ADX:
            begin
                alu_b   = dx_reg;
                alu_sub = dx_reg[ERR_W-1];
            end
            SEL_ADY:
            begin
                alu_b   = dy_reg;
                alu_sub = dy_reg[ERR_W-1];
            end
            SEL_CMP:
            begin
                alu_a   = dx_reg;
                alu_b   = dy_reg;
                alu_sub = 1'b1;
            end
            SEL_ERR:
            begin
                alu_a   = minor2;
                alu_b   = major;
                alu_sub = 1'b1;
            end
            SEL_INC:
            begin
                alu_a   = minor2;
                alu_b   = err_t'(major <<< 1);
                alu_sub = 1'b1;
            end
            SEL_STEP:
            begin
                alu_a = err_reg;
                alu_b = move_minor ? inc_move_reg : minor2;
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
    end

    lr_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum)
    );

    lr_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.in_ready && s_tvalid)
        begin
            x_reg  <= clamp_coord(s_tdata[5:0], MAX_C);
            y_reg  <= clamp_coord(s_tdata[11:6], MAX_C);
            ex_reg <= clamp_coord(s_tdata[17:12], MAX_C);
            ey_reg <= clamp_coord(s_tdata[23:18], MAX_C);
        end
        case (ctrl.alu_sel)
            SEL_DX:
            begin
                dx_reg     <= alu_sum;
                sx_neg_reg <= alu_sum[ERR_W-1];
            end
            SEL_DY:
            begin
                dy_reg     <= alu_sum;
                sy_neg_reg <= alu_sum[ERR_W-1];
            end
            SEL_ADX: dx_reg <= alu_sum;
            SEL_ADY: dy_reg <= alu_sum;
            SEL_CMP: x_major_reg <= !alu_sum[ERR_W-1] && (alu_sum != '0);
            SEL_ERR:
            begin
                err_reg <= alu_sum;
                cnt_reg <= coord_t'(major);
            end
            SEL_INC: inc_move_reg <= alu_sum;
            default:
            begin
            end
        endcase
        if (ctrl.step)
        begin
            // advance along the major axis, minor axis when the error allows
            err_reg <= alu_sum;
            cnt_reg <= coord_t'(cnt_reg - 1'b1);
            if (x_major_reg || move_minor)
            begin
                x_reg <= x_step;
            end
            if (!x_major_reg || move_minor)
            begin
                y_reg <= y_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            pix_x_reg <= (x_major_reg || move_minor) ? x_step : x_reg;
            pix_y_reg <= (!x_major_reg || move_minor) ? y_step : y_reg;
            last_reg  <= stat.last_step;
        end
    end

    assign s_tready = ctrl.in_ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - 2*COORD_W){1'b0}}, pix_y_reg, pix_x_reg};
    assign m_tlast  = last_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a segment is in work");

    a_step_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.step |-> (cnt_reg != '0))
        else $error("pixel step with no steps left");

    a_step_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.step |-> (!m_tvalid || m_tready))
        else $error("pixel step overwrote a waiting item");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.step && stat.last_step) |=> (s_tready && m_tvalid && m_tlast))
        else $error("end pixel not followed by idle");

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the line rasterizer
// Sends directed and random segments with random gaps and back-pressure and
// compares every emitted pixel with a Bresenham pixel predictor in the bench.
// ----------------------------------------------------------------------------
module tb_top;
    import lr_pkg::*;

    localparam int TILE        = 64;
    localparam int N_ROWS      = 25;
    localparam int N_RANDOM    = 145;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN       = 80;

    typedef struct packed {
        coord_t end_y;
        coord_t end_x;
        coord_t start_y;
        coord_t start_x;
    } segment_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } pixel_t;

    typedef struct packed {
        coord_t     start_x, start_y, end_x, end_y;
        logic       typed;
        logic [6:0] n_pix;
        coord_t     end_pix_x, end_pix_y;
    } seg_row_t;

    // start_x, start_y, end_x, end_y, typed, pixel count, end pixel x, end pixel y
    seg_row_t directed_rows [N_ROWS] = '{
        '{ 0,  0,  0,  0, 1, 0,  0,  0},
        '{63, 63, 63, 63, 1, 0,  0,  0},
        '{42, 21, 42, 21, 1, 0,  0,  0},
        '{ 0,  0,  1,  0, 1, 1,  1,  0},
        '{63, 63, 62, 63, 1, 1, 62, 63},
        '{ 5,  5,  6,  6, 1, 1,  6,  6},
        '{21, 42, 21, 41, 1, 1, 21, 41},
        '{ 0,  0, 63,  0, 0, 0,  0,  0},
        '{63,  0,  0,  0, 0, 0,  0,  0},
        '{ 0,  0,  0, 63, 0, 0,  0,  0},
        '{ 0, 63,  0,  0, 0, 0,  0,  0},
        '{ 0,  0, 63, 63, 0, 0,  0,  0},
        '{63, 63,  0,  0, 0, 0,  0,  0},
        '{ 0, 63, 63,  0, 0, 0,  0,  0},
        '{63,  0,  0, 63, 0, 0,  0,  0},
        '{ 0,  0, 63,  1, 0, 0,  0,  0},
        '{ 0,  0,  1, 63, 0, 0,  0,  0},
        '{63,  0,  0, 62, 0, 0,  0,  0},
        '{10, 20, 50, 35, 0, 0,  0,  0},
        '{50, 35, 10, 20, 0, 0,  0,  0},
        '{10, 20, 35, 50, 0, 0,  0,  0},
        '{35, 50, 10, 20, 0, 0,  0,  0},
        '{20, 10,  5, 40, 0, 0,  0,  0},
        '{40,  5,  2, 30, 0, 0,  0,  0},
        '{21, 42, 42, 21, 0, 0,  0,  0}
    };

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // start_x, start_y, end_x, end_y
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // pix_x, pix_y, zero pad
    logic                 m_tlast;         // last

    pixel_t pending_pixels [$];
    int     mismatches  = 0;
    int     pixels_seen = 0;
    int     hold_cycles = 0;

    line_rasterizer #(
        .TILE_SIZE (TILE)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int tile_coord(coord_t v);
        return (v > TILE - 1) ? TILE - 1 : v;
    endfunction

    // queue the pixels of one segment, start pixel excluded
    function automatic void plot_segment(segment_t seg);
        int     x, y, x_end, y_end, dx, dy, step_x, step_y;
        int     major, minor, err, i;
        bit     x_major, move_minor;
        pixel_t px;
        x      = tile_coord(seg.start_x);
        y      = tile_coord(seg.start_y);
        x_end  = tile_coord(seg.end_x);
        y_end  = tile_coord(seg.end_y);
        dx     = x_end - x;
        dy     = y_end - y;
        step_x = (dx < 0) ? -1 : 1;
        step_y = (dy < 0) ? -1 : 1;
        dx     = (dx < 0) ? -dx : dx;
        dy     = (dy < 0) ? -dy : dy;
        x_major = dx > dy;
        major   = x_major ? dx : dy;
        minor   = x_major ? dy : dx;
        err     = 2 * minor - major;
        for (i = 0; i < major && i < 63; i++)
        begin
            move_minor = err >= 0;
            err += move_minor ? 2 * (minor - major) : 2 * minor;
            if (x_major)
            begin
                x += step_x;
                if (move_minor)
                    y += step_y;
            end
            else
            begin
                y += step_y;
                if (move_minor)
                    x += step_x;
            end
            px.x    = coord_t'(x);
            px.y    = coord_t'(y);
            px.last = (i == major - 1);
            pending_pixels.push_back(px);
        end
    endfunction

    function automatic coord_t nudge(coord_t c);
        int v;
        v = int'(c) + $urandom_range(0, 6) - 3;
        return (v < 0) ? 6'd0 : (v > 63) ? 6'd63 : coord_t'(v);
    endfunction

    function automatic segment_t random_segment();
        segment_t seg;
        int       kind, len, a, b;
        seg  = segment_t'($urandom);
        kind = $urandom_range(0, 9);
        if (kind < 3)
        begin
            seg.end_x = nudge(seg.start_x);
            seg.end_y = nudge(seg.start_y);
        end
        else if (kind == 3)
            seg.end_y = seg.start_y;
        else if (kind == 4)
            seg.end_x = seg.start_x;
        else if (kind == 5)
        begin
            len = $urandom_range(0, 63);
            a   = $urandom_range(0, 63 - len);
            b   = $urandom_range(0, 63 - len);
            seg.start_x = $urandom_range(0, 1) ? coord_t'(a) : coord_t'(a + len);
            seg.end_x   = (seg.start_x == a) ? coord_t'(a + len) : coord_t'(a);
            seg.start_y = $urandom_range(0, 1) ? coord_t'(b) : coord_t'(b + len);
            seg.end_y   = (seg.start_y == b) ? coord_t'(b + len) : coord_t'(b);
        end
        else if (kind == 6)
        begin
            seg.start_x = $urandom_range(0, 1) ? 6'd63 : 6'd0;
            seg.start_y = $urandom_range(0, 1) ? 6'd63 : 6'd0;
            seg.end_x   = $urandom_range(0, 1) ? 6'd63 : 6'd0;
            seg.end_y   = $urandom_range(0, 1) ? 6'd63 : 6'd0;
        end
        return seg;
    endfunction

    // bursts with no gap in every third stretch of items
    function automatic int draw_gap(int n);
        return ((n / 24) % 3 == 2) ? 0 : $urandom_range(0, 16);
    endfunction

    task automatic send_segment(segment_t seg, int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= seg;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic void note_mismatch(string what, pixel_t want, pixel_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     $realtime, what, want.x, want.y, want.last, got.x, got.y, got.last);
    endfunction

    initial
    begin
        segment_t seg;
        pixel_t   px;
        int       n;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (directed_rows[r])
        begin
            seg.start_x = directed_rows[r].start_x;
            seg.start_y = directed_rows[r].start_y;
            seg.end_x   = directed_rows[r].end_x;
            seg.end_y   = directed_rows[r].end_y;
            send_segment(seg, draw_gap(r));
            if (!directed_rows[r].typed)
                plot_segment(seg);
            else if (directed_rows[r].n_pix != 0)
            begin
                px.x    = directed_rows[r].end_pix_x;
                px.y    = directed_rows[r].end_pix_y;
                px.last = 1'b1;
                pending_pixels.push_back(px);
            end
        end
        for (n = 0; n < N_RANDOM; n++)
        begin
            seg = random_segment();
            send_segment(seg, draw_gap(n));
            plot_segment(seg);
        end
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_pixels
        pixel_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.x    = m_tdata[COORD_W-1:0];
            got.y    = m_tdata[2*COORD_W-1:COORD_W];
            got.last = m_tlast;
            if (pending_pixels.size() == 0)
                note_mismatch("unexpected item", '0, got);
            else
            begin
                want = pending_pixels.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.last !== want.last)
                    note_mismatch("pixel mismatch", want, got);
            end
            pixels_seen++;
            // hold ready high through every third stretch of pixels
            hold_cycles = ((pixels_seen / 150) % 3 == 1) ? 0 : $urandom_range(0, 16);
        end
    end

endmodule
`default_nettype wire

### sim.f
sv/lr_pkg.sv
sv/lr_alu.sv
sv/lr_seq.sv
sv/line_rasterizer.sv
verif/tb_top.sv
